// ===== design/wbps_pkg.sv =====
package wbps_pkg;

  // Number of pattern bytes the register file can hold.
  localparam int PAT_BYTES = 32;

  // Default window length of the scanner.
  localparam int MAX_PATTERN_BYTES_DEF = 32;

  // Width of the pattern length register.
  localparam int LEN_W = 6;

  // Width of an address or offset in the scanned range.
  localparam int ADDR_W = 64;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int WILD_W = 32;

  // Register indexes, at byte address 8 * index.
  typedef enum logic [2:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_WILD = 3'd4,
    REG_LEN  = 3'd5,
    REG_BASE = 3'd6
  } reg_idx_t;

  // Current configuration as seen by the scan logic.
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [WILD_W-1:0]         wild;
    logic [LEN_W-1:0]          len;
    logic [ADDR_W-1:0]         base;
  } cfg_t;

  // Control shared by every cell of the window chain.
  typedef struct packed {
    logic             shift_en;
    logic [LEN_W-1:0] eff_len;
  } cell_ctrl_t;

endpackage

// ===== design/wbps_cfg_regs.sv =====
module wbps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output wbps_pkg::cfg_t                      cfg
);

  wbps_pkg::cfg_t     cfg_r;
  wbps_pkg::reg_idx_t sel_idx;
  logic               wr_en;

  // The port never stalls; a write lands in the access cycle.
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign sel_idx    = wbps_pkg::reg_idx_t'(cfg_paddr[5:3]);

  // Register file with its reset values; writes to unused slots are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat  <= '0;
      cfg_r.wild <= '0;
      cfg_r.len  <= wbps_pkg::LEN_W'(1);
      cfg_r.base <= '0;
    end else if (wr_en) begin
      case (sel_idx)
        wbps_pkg::REG_PAT0: cfg_r.pat[7:0]   <= cfg_pwdata;
        wbps_pkg::REG_PAT1: cfg_r.pat[15:8]  <= cfg_pwdata;
        wbps_pkg::REG_PAT2: cfg_r.pat[23:16] <= cfg_pwdata;
        wbps_pkg::REG_PAT3: cfg_r.pat[31:24] <= cfg_pwdata;
        wbps_pkg::REG_WILD: cfg_r.wild <= cfg_pwdata[wbps_pkg::WILD_W-1:0];
        wbps_pkg::REG_LEN:  cfg_r.len  <= cfg_pwdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_BASE: cfg_r.base <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (sel_idx)
      wbps_pkg::REG_PAT0: cfg_prdata = cfg_r.pat[7:0];
      wbps_pkg::REG_PAT1: cfg_prdata = cfg_r.pat[15:8];
      wbps_pkg::REG_PAT2: cfg_prdata = cfg_r.pat[23:16];
      wbps_pkg::REG_PAT3: cfg_prdata = cfg_r.pat[31:24];
      wbps_pkg::REG_WILD: cfg_prdata = wbps_pkg::CFG_DATA_W'(cfg_r.wild);
      wbps_pkg::REG_LEN:  cfg_prdata = wbps_pkg::CFG_DATA_W'(cfg_r.len);
      wbps_pkg::REG_BASE: cfg_prdata = cfg_r.base;
      default:            cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/wbps_cell.sv =====
module wbps_cell #(
  parameter int IDX = 0
) (
  input  logic                                     clk,
  input  wbps_pkg::cell_ctrl_t                     ctrl,
  input  logic [wbps_pkg::PAT_BYTES-1:0][7:0]      pat,
  input  logic [wbps_pkg::WILD_W-1:0]              wild,
  input  logic [7:0]                               byte_in,
  output logic [7:0]                               byte_out,
  output logic                                     hit
);

  localparam int LW = wbps_pkg::LEN_W;
  localparam int PW = $clog2(wbps_pkg::PAT_BYTES);
  localparam logic [LW-1:0] CELL_POS = LW'(IDX);
  localparam logic [LW-1:0] CELL_NEXT = LW'(IDX + 1);

  logic [7:0]    byte_r;
  logic [LW-1:0] pat_sel;
  logic [PW-1:0] pat_idx;
  logic          in_use;

  // One window entry; it takes its neighbor's byte on every accepted beat.
  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // With the newest byte in entry 0, this entry faces pattern byte len-1-IDX.
  assign pat_sel = ctrl.eff_len - CELL_NEXT;
  assign pat_idx = pat_sel[PW-1:0];
  assign in_use  = (CELL_POS < ctrl.eff_len);

  // Compare the byte this entry is about to hold; entries past the length pass.
  assign hit = !in_use || wild[pat_idx] || (byte_in == pat[pat_idx]);

endmodule

// ===== design/wildcard_byte_pattern_scanner_core.sv =====
// A result beat appears in the cycle after the end-of-range byte is taken.
// Throughput: one byte per cycle; the window compare is done in the cell row in parallel.
// The input stalls only while a result beat waits and the output is not ready.
// Reset (synchronous, rst_n low) clears the scan state, the output valid and found
// flags and the registers (pattern length to 1, all else to 0); no clearing pass is needed.
module wildcard_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // end_of_range
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wbps_pkg::ADDR_W-1:0]      out_tdata,  // [63:0] match_address
  output logic [0:0]                       out_tuser,  // [0] match_found
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  localparam int LW = wbps_pkg::LEN_W;
  localparam int AW = wbps_pkg::ADDR_W;
  localparam int SW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN_BYTES);
  localparam logic [SW-1:0] SEEN_MAX = SW'(MAX_PATTERN_BYTES);

  wbps_pkg::cfg_t       cfg;
  wbps_pkg::cell_ctrl_t ctrl;

  logic [LW-1:0] eff_len;
  logic          accept;
  logic [7:0]    win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  logic [SW-1:0] seen_r, seen_nxt;
  logic [AW-1:0] offset_r, offset_nxt;
  logic          have_r, have_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] mbase_r, mbase_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [AW-1:0] out_start_r, out_start_nxt;
  logic [AW-1:0] out_base_r, out_base_nxt;

  logic [SW-1:0] seen_inc;
  logic          hit_now;
  logic [AW-1:0] start_now;

  // Register file.
  wbps_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Clamp the pattern length into the window size; a length of zero acts as one.
  always_comb begin
    if (cfg.len == '0) begin
      eff_len = LW'(1);
    end else if (cfg.len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = cfg.len;
    end
  end

  assign accept        = in_tvalid & in_tready;
  assign in_tready     = ~out_valid_r | out_tready;
  assign ctrl.shift_en = accept;
  assign ctrl.eff_len  = eff_len;

  // Row of window cells, newest byte in cell 0.
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [7:0] cell_in;
    if (k == 0) begin : g_head
      assign cell_in = in_tdata;
    end else begin : g_link
      assign cell_in = win[k-1];
    end
    wbps_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pat      (cfg.pat),
      .wild     (cfg.wild),
      .byte_in  (cell_in),
      .byte_out (win[k]),
      .hit      (hits[k])
    );
  end

  // A new match needs as many bytes from this range as the pattern length and no earlier match.
  assign seen_inc  = (seen_r < SEEN_MAX) ? seen_r + SW'(1) : seen_r;
  assign hit_now   = (&hits) && (LW'(seen_inc) >= eff_len) && !have_r;
  assign start_now = offset_r - AW'(eff_len - LW'(1));

  // Scan state and output stage update.
  always_comb begin
    seen_nxt      = seen_r;
    offset_nxt    = offset_r;
    have_nxt      = have_r;
    start_nxt     = start_r;
    mbase_nxt     = mbase_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_base_nxt  = out_base_r;
    if (accept) begin
      if (in_tlast) begin
        seen_nxt      = '0;
        offset_nxt    = '0;
        have_nxt      = 1'b0;
        start_nxt     = '0;
        mbase_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_found_nxt = have_r | hit_now;
        if (have_r) begin
          out_start_nxt = start_r;
          out_base_nxt  = mbase_r;
        end else if (hit_now) begin
          out_start_nxt = start_now;
          out_base_nxt  = cfg.base;
        end else begin
          out_start_nxt = '0;
          out_base_nxt  = '0;
        end
      end else begin
        seen_nxt   = seen_inc;
        offset_nxt = offset_r + AW'(1);
        if (hit_now) begin
          have_nxt  = 1'b1;
          start_nxt = start_now;
          mbase_nxt = cfg.base;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      offset_r    <= '0;
      have_r      <= 1'b0;
      start_r     <= '0;
      mbase_r     <= '0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      offset_r    <= offset_nxt;
      have_r      <= have_nxt;
      start_r     <= start_nxt;
      mbase_r     <= mbase_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_start_r <= out_start_nxt;
    out_base_r  <= out_base_nxt;
  end

  // The match address is base plus window start, both zero when nothing matched.
  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_found_r;
  assign out_tdata    = out_base_r + out_start_r;

  // A result beat only starts after an end-of-range byte is taken.
  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && in_tlast))
    else $error("result beat without an end-of-range byte");

  // No match means address zero.
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_tdata == '0))
    else $error("nonzero address without a match");

  // The end of a range leaves the scan state cleared.
  a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (seen_r == '0 && offset_r == '0 && !have_r))
    else $error("scan state not cleared after end of range");

  // The byte count saturates at the window size.
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_MAX)
    else $error("byte count past window size");

endmodule

// ===== tb/wildcard_byte_pattern_scanner_core_tb.sv =====
module wildcard_byte_pattern_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_BYTES = 32;
  localparam int TARGET_BYTES = 1875;
  localparam int CALM_BYTES = 1550;
  localparam int PRESSURE_PHASE = 3;
  localparam int LONG_HOLD_CYCLES = 150;

  // One input beat and one result beat as the scoreboard sees them.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_byte_t;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = '0;    // [7:0] data_byte
  logic                            in_tlast = 1'b0;  // end_of_range
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wbps_pkg::ADDR_W-1:0]     out_tdata;        // [63:0] match_address
  logic [0:0]                      out_tuser;        // [0] match_found
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [wbps_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  wildcard_byte_pattern_scanner_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Bytes waiting to be sent and results waiting to arrive.
  scan_byte_t   byte_feed[$];
  scan_result_t expected_results[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int fail_count = 0;

  // Idle control shared between the stimulus and the two handshake processes.
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;
  bit  want_long_hold = 1'b0;

  // Register copies as the scanner should hold them.
  logic [255:0] pat_bits = '0;
  logic [31:0]  wild_bits = '0;
  logic [5:0]   len_reg = 6'd1;
  logic [63:0]  base_reg = '0;

  // Scan state of the current range.
  logic [7:0]  win [WIN_BYTES];
  int          seen = 0;
  logic [63:0] next_offset = '0;
  logic        hit = 1'b0;
  logic [63:0] hit_addr = '0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Length in use: zero acts as one, anything over the window as the window.
  function automatic int active_len();
    int len;
    len = int'(len_reg);
    if (len == 0) len = 1;
    if (len > WIN_BYTES) len = WIN_BYTES;
    return len;
  endfunction

  function automatic logic [7:0] pat_byte(input int i);
    return pat_bits[i*8 +: 8];
  endfunction

  // Shift one byte into the window, record the first match and close the
  // range on its last byte.
  task automatic scan_predict(input logic [7:0] d, input logic last);
    int          len;
    logic [63:0] here;
    bit          ok;
    scan_result_t r;
    len = active_len();
    here = next_offset;
    for (int k = WIN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = d;
    if (seen < WIN_BYTES) seen++;
    next_offset = here + 64'd1;
    if (!hit && seen >= len) begin
      ok = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (!wild_bits[i] && win[len-1-i] != pat_byte(i)) ok = 1'b0;
      end
      if (ok) begin
        hit = 1'b1;
        hit_addr = base_reg + (here - 64'(len - 1));
      end
    end
    if (last) begin
      r.found = hit;
      r.addr = hit ? hit_addr : 64'd0;
      expected_results.insert(expected_results.size(), r);
      foreach (win[k]) win[k] = 8'd0;
      seen = 0;
      next_offset = '0;
      hit = 1'b0;
      hit_addr = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Input driver: holds a beat until it is taken, then sends the next one
  // or idles for a burst.
  always @(posedge clk) begin
    scan_byte_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (byte_feed.size() > 0) begin
        b = byte_feed.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= b.data;
        in_tlast <= b.last;
        if ($urandom_range(0, 99) < in_idle_pct) in_gap <= $urandom_range(1, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result ready: one long hold during the pressure phase, random bursts
  // otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      long_hold_left <= 0;
    end else if (long_hold_left > 0) begin
      out_tready <= 1'b0;
      long_hold_left <= long_hold_left - 1;
    end else if (want_long_hold && !long_hold_done) begin
      out_tready <= 1'b0;
      long_hold_done <= 1'b1;
      long_hold_left <= LONG_HOLD_CYCLES - 1;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_tready <= 1'b0;
      out_gap <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on every accepted input beat, then check result beats.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        scan_predict(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", out_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser[0] !== want.found)
            report_mismatch("match_found", 64'(out_tuser[0]), 64'(want.found));
          if (out_tdata !== want.addr)
            report_mismatch("match_address", out_tdata, want.addr);
        end
      end
    end
  end

  // Register write over the configuration port; the copy is updated at the
  // access edge.
  task automatic cfg_write(input wbps_pkg::reg_idx_t idx, input logic [63:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= wbps_pkg::CFG_ADDR_W'(int'(idx) * 8);
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      wbps_pkg::REG_PAT0, wbps_pkg::REG_PAT1, wbps_pkg::REG_PAT2, wbps_pkg::REG_PAT3:
        pat_bits[(int'(idx) - int'(wbps_pkg::REG_PAT0))*64 +: 64] = v;
      wbps_pkg::REG_WILD: wild_bits = v[31:0];
      wbps_pkg::REG_LEN:  len_reg = v[5:0];
      wbps_pkg::REG_BASE: base_reg = v;
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] d, input logic last);
    scan_byte_t b;
    b.data = d;
    b.last = last;
    byte_feed.insert(byte_feed.size(), b);
    bytes_queued++;
  endtask

  // Wait for every byte to be taken and every result to arrive, then let
  // the output stage settle.
  task automatic drain();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || expected_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_reg_value(input wbps_pkg::reg_idx_t idx);
    int          r;
    logic [63:0] v;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    case (idx)
      wbps_pkg::REG_WILD: begin
        if (r < 40) v = '0;
        else if (r < 45) v = 64'hFFFF_FFFF;
        else if (r < 75) v[31:0] = $urandom & $urandom & $urandom;
      end
      wbps_pkg::REG_LEN: begin
        if (r < 5) v[5:0] = 6'd0;
        else if (r < 10) v[5:0] = 6'd32;
        else if (r < 14) v[5:0] = 6'd63;
        else if (r < 18) v[5:0] = 6'($urandom_range(33, 62));
        else if (r < 35) v[5:0] = 6'($urandom_range(9, 31));
        else v[5:0] = 6'($urandom_range(1, 8));
        if ($urandom_range(0, 3) != 0) v[63:6] = '0;
      end
      wbps_pkg::REG_BASE: begin
        if (r < 10) v = '0;
        else if (r < 20) v = '1;
        else if (r < 35) v = 64'd0 - 64'($urandom_range(1, 64));
      end
      default: begin
        if (r < 10) v = '0;
        else if (r < 20) v = '1;
      end
    endcase
    return v;
  endfunction

  // One range of n bytes: the pattern planted at a random spot, each byte
  // drawn from the pattern with even odds, or plain noise.
  task automatic queue_range(input int n, input bit close);
    int         len;
    int         p;
    int         style;
    int         pos;
    logic [7:0] b;
    len = active_len();
    p = (n >= len) ? $urandom_range(0, n - len) : -1;
    style = $urandom_range(0, 99);
    for (int j = 0; j < n; j++) begin
      b = 8'($urandom);
      if (style < 60) begin
        pos = j - p;
        if (p >= 0 && pos >= 0 && pos < len && !wild_bits[pos]) b = pat_byte(pos);
      end else if (style < 85) begin
        if ($urandom_range(0, 1) == 1) b = pat_byte($urandom_range(0, len - 1));
      end
      push_byte(b, close && j == n - 1);
    end
  endtask

  initial begin
    int phase_bytes;
    int n;
    int phase;
    phase = 0;
    foreach (win[k]) win[k] = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: a one-byte pattern of zero at base zero.
    in_idle_pct = 20;
    out_idle_pct = 20;
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    // Four-byte pattern with a wildcard in the middle, stray mask bits above
    // the length, and a base that wraps past the top of the address space.
    cfg_write(wbps_pkg::REG_PAT0, 64'h1234_5678_EF00_ADDE);
    cfg_write(wbps_pkg::REG_PAT1, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(wbps_pkg::REG_PAT2, 64'h0000_0000_0000_0000);
    cfg_write(wbps_pkg::REG_PAT3, 64'h0123_4567_89AB_CDEF);
    cfg_write(wbps_pkg::REG_WILD, 64'h0000_0000_FFFF_FFF4);
    cfg_write(wbps_pkg::REG_LEN, 64'd4);
    cfg_write(wbps_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
    @(negedge clk);
    // A range shorter than the pattern, then a match ending on the last byte.
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hEF, 1'b1);
    drain();

    // Base changed in the middle of a range before the match is seen.
    push_byte(8'h00, 1'b0);
    push_byte(8'hDE, 1'b0);
    drain();
    cfg_write(wbps_pkg::REG_BASE, 64'h1000);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h99, 1'b0);
    push_byte(8'hEF, 1'b1);
    drain();

    // Base changed after a match is recorded: the recorded address stays.
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEF, 1'b0);
    drain();
    cfg_write(wbps_pkg::REG_BASE, 64'h2000);
    push_byte(8'h42, 1'b1);
    drain();

    // A length of zero acts as one.
    cfg_write(wbps_pkg::REG_LEN, 64'd0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hDE, 1'b1);
    drain();

    // Random phases: new settings, then a batch of ranges.
    while (bytes_queued < TARGET_BYTES) begin
      phase++;
      for (int k = int'(wbps_pkg::REG_PAT0); k <= int'(wbps_pkg::REG_BASE); k++) begin
        if ($urandom_range(0, 99) < 60)
          cfg_write(wbps_pkg::reg_idx_t'(k), pick_reg_value(wbps_pkg::reg_idx_t'(k)));
      end
      @(negedge clk);
      if (bytes_queued > CALM_BYTES) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: in_idle_pct = 0;
          1: in_idle_pct = 5;
          2: in_idle_pct = 20;
          default: in_idle_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0: out_idle_pct = 0;
          1: out_idle_pct = 5;
          2: out_idle_pct = 20;
          default: out_idle_pct = 40;
        endcase
      end

      if (phase == PRESSURE_PHASE) begin
        // Many short ranges while the receiver holds off.
        in_idle_pct = 0;
        want_long_hold = 1'b1;
        for (int r = 0; r < 40; r++) queue_range($urandom_range(1, 2), 1'b1);
      end else begin
        phase_bytes = $urandom_range(80, 160);
        n = 0;
        while (n < phase_bytes) begin
          if ($urandom_range(0, 9) == 0) n += 0;
          if ($urandom_range(0, 9) == 0) begin
            queue_range($urandom_range(1, 4), 1'b1);
            n += 4;
          end else begin
            queue_range(active_len() + $urandom_range(0, 12) - 3 > 0 ?
                        active_len() + $urandom_range(0, 12) - 3 : 1, 1'b1);
            n += active_len() + 6;
          end
        end
        // Sometimes leave a range open across the next settings change.
        if (bytes_queued < CALM_BYTES && $urandom_range(0, 4) == 0)
          queue_range($urandom_range(1, active_len() + 4), 1'b0);
      end
      drain();
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
design/wbps_pkg.sv
design/wbps_cfg_regs.sv
design/wbps_cell.sv
design/wildcard_byte_pattern_scanner_core.sv
tb/wildcard_byte_pattern_scanner_core_tb.sv
